// ===== rtl/core/cksb_pkg.sv =====
// Shared types and constants of the color-key sprite blitter.
`default_nettype none
package cksb_pkg;

  localparam int PixelWidth = 16;
  localparam int CoordWidth = 12;
  localparam int AddrWidth  = 22;
  localparam int CfgWidth   = 16;
  localparam int CfgIdxWidth = 3;

  // Bit positions inside the mode register.
  localparam int ModeWide = 0;
  localparam int ModeDraw = 1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SPRITE_WIDTH = 3'd0,
    REG_POS_X        = 3'd1,
    REG_POS_Y        = 3'd2,
    REG_DEST_WIDTH   = 3'd3,
    REG_DEST_HEIGHT  = 3'd4,
    REG_DEST_PITCH   = 3'd5,
    REG_KEY_COLOR    = 3'd6,
    REG_MODE         = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [10:0]           sprite_width;
    logic [CoordWidth-1:0] pos_x;
    logic [CoordWidth-1:0] pos_y;
    logic [CoordWidth-1:0] dest_width;
    logic [CoordWidth-1:0] dest_height;
    logic [CoordWidth-1:0] dest_pitch;
    logic [PixelWidth-1:0] key_color;
    logic [1:0]            mode;
  } cfg_t;

  // One classified pixel waiting for its address.
  typedef struct packed {
    logic                  enable;
    logic [CoordWidth-1:0] dx;
    logic [CoordWidth-1:0] dy;
    logic [PixelWidth-1:0] data;
    logic                  done;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/cksb_in_if.sv =====
// Pixel input channel of the sprite blitter.
`default_nettype none
interface cksb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic        end_of_sprite;

  modport source (output valid, output pixel, output end_of_sprite, input ready);
  modport sink   (input valid, input pixel, input end_of_sprite, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cksb_out_if.sv =====
// Write result channel of the sprite blitter.
`default_nettype none
interface cksb_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [21:0] write_address;
  logic [15:0] write_data;
  logic        sprite_done;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output sprite_done, input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input write_data, input sprite_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cksb_front.sv =====
// Front end: raster counters, clipping and color-key test.
`default_nettype none
module cksb_front #(
  parameter int MAX_SPRITE_WIDTH  = 1024,
  parameter int MAX_SPRITE_HEIGHT = 1024,
  parameter int MAX_DEST_SIZE     = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cksb_pkg::cfg_t                    cfg,
  input  wire logic                              accept,
  input  wire logic [cksb_pkg::PixelWidth-1:0]   pixel,
  input  wire logic                              end_of_sprite,
  output cksb_pkg::entry_t                       entry
);
  localparam int CW = (MAX_SPRITE_WIDTH > 1) ? $clog2(MAX_SPRITE_WIDTH) : 1;
  localparam int RW = (MAX_SPRITE_HEIGHT > 1) ? $clog2(MAX_SPRITE_HEIGHT) : 1;
  localparam int MW = (CW > RW) ? CW : RW;
  localparam int PW = ((MW > cksb_pkg::CoordWidth) ? MW : cksb_pkg::CoordWidth) + 2;
  localparam logic [12:0] SW_CAP = 13'(MAX_SPRITE_WIDTH);
  localparam logic [12:0] ROW_CAP = 13'(MAX_SPRITE_HEIGHT);
  // Destination registers hold at most 4095, so a cap at or above that is a no-op.
  localparam logic [cksb_pkg::CoordWidth-1:0] DEST_CAP =
    (MAX_DEST_SIZE > 4095) ? 12'hFFF : 12'(MAX_DEST_SIZE);

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;

  logic [12:0]                         sw;
  logic [cksb_pkg::CoordWidth-1:0]     dw, dh;
  logic signed [PW-1:0]                dx, dy;
  logic                                in_rect, wide, draw, enable;
  logic [cksb_pkg::PixelWidth-1:0]     pix, key;

  always_comb begin
    sw = {2'b00, cfg.sprite_width};
    if (sw == 13'd0) sw = 13'd1;
    if (sw > SW_CAP) sw = SW_CAP;
    dw = (cfg.dest_width > DEST_CAP) ? DEST_CAP : cfg.dest_width;
    dh = (cfg.dest_height > DEST_CAP) ? DEST_CAP : cfg.dest_height;

    dx = $signed({{(PW-cksb_pkg::CoordWidth){cfg.pos_x[cksb_pkg::CoordWidth-1]}}, cfg.pos_x})
       + $signed({{(PW-CW){1'b0}}, column_count});
    dy = $signed({{(PW-cksb_pkg::CoordWidth){cfg.pos_y[cksb_pkg::CoordWidth-1]}}, cfg.pos_y})
       + $signed({{(PW-RW){1'b0}}, row_count});
    in_rect = !dx[PW-1] && !dy[PW-1] &&
              (dx < $signed({{(PW-cksb_pkg::CoordWidth){1'b0}}, dw})) &&
              (dy < $signed({{(PW-cksb_pkg::CoordWidth){1'b0}}, dh}));

    wide = cfg.mode[cksb_pkg::ModeWide];
    draw = cfg.mode[cksb_pkg::ModeDraw];
    pix  = wide ? pixel : {8'h00, pixel[7:0]};
    key  = wide ? cfg.key_color : {8'h00, cfg.key_color[7:0]};
    enable = in_rect && !(draw && (pix == key));

    entry.enable = enable;
    entry.dx     = dx[cksb_pkg::CoordWidth-1:0];
    entry.dy     = dy[cksb_pkg::CoordWidth-1:0];
    entry.data   = enable ? pix : '0;
    entry.done   = end_of_sprite;
  end

  // Advance the raster position; restart after the last pixel of a sprite.
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (end_of_sprite) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if ((13'(column_count) + 13'd1) >= sw) begin
      column_count_next = '0;
      if ((13'(row_count) + 13'd1) < ROW_CAP) row_count_next = row_count + 1'b1;
    end else begin
      column_count_next = column_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/cksb_queue.sv =====
// Two-entry queue between the front and back ends.
`default_nettype none
module cksb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cksb_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output cksb_pkg::entry_t      head
);
  cksb_pkg::entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/cksb_back.sv =====
// Back end: address generation and the output register.
`default_nettype none
module cksb_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [cksb_pkg::CoordWidth-1:0]     dest_pitch,
  input  wire logic                                q_valid,
  input  wire cksb_pkg::entry_t                    q_head,
  output logic                                     q_pop,
  cksb_out_if.source                               out_ch
);
  logic [2*cksb_pkg::CoordWidth-1:0] product;
  logic [cksb_pkg::AddrWidth-1:0]    addr;

  assign q_pop   = q_valid && (!out_ch.valid || out_ch.ready);
  assign product = q_head.dy * dest_pitch;
  assign addr    = cksb_pkg::AddrWidth'(product + (2*cksb_pkg::CoordWidth)'(q_head.dx));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (q_pop) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_ch.write_enable  <= q_head.enable;
      out_ch.write_address <= q_head.enable ? addr : '0;
      out_ch.write_data    <= q_head.data;
      out_ch.sprite_done   <= q_head.done;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/color_key_sprite_blitter.sv =====
// Color-key sprite blitter top level: configuration registers and datapath.
// Usage:
//   Sprite pixels come in on in_ch in raster order, one beat per pixel, with
//   end_of_sprite set on the last one. Every input beat yields exactly one
//   output beat on out_ch: write_enable tells whether the frame buffer is
//   written, write_address is (pos_y+row)*pitch+(pos_x+column) and
//   write_data is the pixel, cut to 8 bits in 8-bit mode (both zero when not enabled).
//   Registers are written through cfg_write/cfg_index/cfg_data, one per cycle;
//   the user writes them only while no pixel is in flight; the block does not enforce it.
// Timing:
//   The front end classifies a pixel in the cycle it arrives and pushes it
//   into the queue at the accepting edge; the back end's single 12x12
//   multiply for the address then loads the output register when that
//   register is empty or being taken. One beat per clock is sustained
//   while the receiver keeps out_ch.ready high.
//   A two-entry queue decouples the two halves; in_ch.ready drops only when
//   it is full, so a stalled receiver backs up into the sender after two
//   more beats and no beat is lost.
// Reset (rst, synchronous): counters restart at the sprite origin, the queue
//   and output register empty, and registers return to width 1, destination
//   1x1, pitch 1, position 0, key 0, 8-bit blit mode.
`default_nettype none
module color_key_sprite_blitter #(
  parameter int MAX_SPRITE_WIDTH  = 1024,
  parameter int MAX_SPRITE_HEIGHT = 1024,
  parameter int MAX_DEST_SIZE     = 2048
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [cksb_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire logic [cksb_pkg::CfgWidth-1:0]        cfg_data,
  cksb_in_if.sink                                   in_ch,
  cksb_out_if.source                                out_ch
);
  cksb_pkg::cfg_t   cfg;
  cksb_pkg::entry_t front_entry, q_head;
  logic             q_full, q_valid, q_pop, accept;

  // Hold the register file; each write lands in one field.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_width <= 11'd1;
      cfg.pos_x        <= '0;
      cfg.pos_y        <= '0;
      cfg.dest_width   <= 12'd1;
      cfg.dest_height  <= 12'd1;
      cfg.dest_pitch   <= 12'd1;
      cfg.key_color    <= '0;
      cfg.mode         <= '0;
    end else if (cfg_write) begin
      unique case (cksb_pkg::cfg_index_t'(cfg_index))
        cksb_pkg::REG_SPRITE_WIDTH: cfg.sprite_width <= cfg_data[10:0];
        cksb_pkg::REG_POS_X:        cfg.pos_x        <= cfg_data[11:0];
        cksb_pkg::REG_POS_Y:        cfg.pos_y        <= cfg_data[11:0];
        cksb_pkg::REG_DEST_WIDTH:   cfg.dest_width   <= cfg_data[11:0];
        cksb_pkg::REG_DEST_HEIGHT:  cfg.dest_height  <= cfg_data[11:0];
        cksb_pkg::REG_DEST_PITCH:   cfg.dest_pitch   <= cfg_data[11:0];
        cksb_pkg::REG_KEY_COLOR:    cfg.key_color    <= cfg_data;
        cksb_pkg::REG_MODE:         cfg.mode         <= cfg_data[1:0];
        default:                    cfg.mode         <= cfg.mode;
      endcase
    end
  end

  // Take a beat whenever the queue has room; the output side never gates it.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  cksb_front #(
    .MAX_SPRITE_WIDTH  (MAX_SPRITE_WIDTH),
    .MAX_SPRITE_HEIGHT (MAX_SPRITE_HEIGHT),
    .MAX_DEST_SIZE     (MAX_DEST_SIZE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .pixel         (in_ch.pixel),
    .end_of_sprite (in_ch.end_of_sprite),
    .entry         (front_entry)
  );

  cksb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  cksb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .dest_pitch (cfg.dest_pitch),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );
endmodule
`default_nettype wire
